### src/ubsd_pkg.sv
package ubsd_pkg;

  localparam int ByteW   = 8;
  localparam int CpW     = 31;
  localparam int LeftW   = 3;
  localparam int ShamtW  = 6;
  localparam int OnesW   = 4;
  localparam int MaskCnt = 9;

  localparam logic [ByteW-1:0] AsciiLimit = 8'h80;
  localparam logic [ShamtW-1:0] ContShift = 6'd6;

  // Entry k has the top k bits of a byte set.
  localparam logic [ByteW-1:0] LeadMask [MaskCnt] = '{
    8'h00, 8'h80, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE, 8'hFF
  };

  typedef struct packed {
    logic [LeftW-1:0] bytes_left;
    logic [CpW-1:0]   accumulator;
  } ubsd_state_t;

  typedef struct packed {
    logic [CpW-1:0] cp_value;
    logic           is_end;
    logic           complete;
  } ubsd_result_t;

endpackage

### src/ubsd_if.sv
interface ubsd_byte_if;
  logic                       valid;
  logic                       ready;
  logic [ubsd_pkg::ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface ubsd_cp_if;
  logic                     valid;
  logic                     ready;
  logic [ubsd_pkg::CpW-1:0] cp_value;
  logic                     is_end;
  logic                     complete;

  modport source (output valid, output cp_value, output is_end, output complete, input ready);
  modport sink (input valid, input cp_value, input is_end, input complete, output ready);
endinterface

### src/utf8_byte_stream_decoder.sv
// UTF-8 byte stream decoder.
//
// Input channel (in_ch): one string byte per item. A zero byte marks the end
// of the string. Result channel (out_ch): one item per decoded code point,
// plus one end item for each zero byte, carrying is_end = 1 and complete = 1
// when no multi-byte sequence was left open. Bytes in the middle of a
// multi-byte sequence produce no result item.
//
// Each accepted byte is held in an input register, then the step logic
// (leading-ones count, mask, shift by six per remaining byte, OR) updates the
// decode state and, when a result is due, loads the result register, which
// drives out_ch.valid. One byte is accepted every cycle as long as the
// result register is empty or being taken in the same cycle.
//
// When the receiver holds out_ch.ready low with a result waiting, the byte in
// the input register waits and in_ch.ready drops once that register is full;
// nothing is lost or repeated. Synchronous reset (rst_n low) empties both
// registers and clears the pending count and the accumulator.
module utf8_byte_stream_decoder (
  input logic         clk,
  input logic         rst_n,
  ubsd_byte_if.sink   in_ch,
  ubsd_cp_if.source   out_ch
);

  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic [ubsd_pkg::ByteW-1:0]  byte_r;
  ubsd_pkg::ubsd_state_t       st_r;
  ubsd_pkg::ubsd_state_t       st_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  ubsd_pkg::ubsd_result_t      res_r;
  ubsd_pkg::ubsd_result_t      step_res;
  logic                        step_emit;
  logic                        out_free;
  logic                        s1_fire;
  logic                        in_fire;

  // The stage moves whenever the result register is empty or is being taken.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  ubsd_step u_step (
    .byte_i (byte_r),
    .st_i   (st_r),
    .st_o   (st_nxt),
    .res_o  (step_res),
    .emit_o (step_emit)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.ready) begin
      s1_valid_nxt = in_ch.valid;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_fire && step_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_ch.byte_in;
    end
    if (s1_fire && step_emit) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.cp_value = res_r.cp_value;
  assign out_ch.is_end   = res_r.is_end;
  assign out_ch.complete = res_r.complete;

  // A byte that yields a result must land in the result register.
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && step_emit |=> out_valid_r)
    else $error("emitted result not loaded");

  // A plain ASCII byte or end of string always closes any open sequence.
  a_ascii_closes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (byte_r < ubsd_pkg::AsciiLimit) |=> st_r.bytes_left == '0)
    else $error("sequence left open after ASCII byte");

  // complete is only ever set on end items.
  a_end_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.is_end |-> !res_r.complete)
    else $error("complete set on a code point item");

  // An end item carries a zero code point.
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.is_end |-> res_r.cp_value == '0)
    else $error("end item with nonzero code point");

endmodule

### src/ubsd_step.sv
module ubsd_step (
  input  logic [ubsd_pkg::ByteW-1:0] byte_i,
  input  ubsd_pkg::ubsd_state_t      st_i,
  output ubsd_pkg::ubsd_state_t      st_o,
  output ubsd_pkg::ubsd_result_t     res_o,
  output logic                       emit_o
);

  logic [ubsd_pkg::OnesW-1:0]  ones;
  logic                        run;
  logic [ubsd_pkg::OnesW-1:0]  left_sel;
  logic [ubsd_pkg::OnesW-1:0]  left_dec;
  logic [ubsd_pkg::LeftW-1:0]  left_new;
  logic [ubsd_pkg::OnesW-1:0]  idx;
  logic [ubsd_pkg::ByteW-1:0]  data;
  logic [ubsd_pkg::ShamtW-1:0] shamt;
  logic [ubsd_pkg::CpW-1:0]    shifted;
  logic [ubsd_pkg::CpW-1:0]    acc_base;
  logic                        idle;

  // Leading-ones count of the byte, 0 to 8.
  always_comb begin
    ones = '0;
    run  = 1'b1;
    for (int i = ubsd_pkg::ByteW - 1; i >= 0; i--) begin
      run = run & byte_i[i];
      ones = ones + {{(ubsd_pkg::OnesW-1){1'b0}}, run};
    end
  end

  assign idle     = (st_i.bytes_left == '0);
  assign left_sel = idle ? ones : {1'b0, st_i.bytes_left};
  assign left_dec = left_sel - 4'd1;
  assign left_new = left_dec[ubsd_pkg::LeftW-1:0];
  assign idx      = (ones == 4'd8) ? 4'd8 : ones + 4'd1;
  assign data     = byte_i & ~ubsd_pkg::LeadMask[idx];
  assign shamt    = 6'({3'b000, left_new} * ubsd_pkg::ContShift);
  assign shifted  = {{(ubsd_pkg::CpW-ubsd_pkg::ByteW){1'b0}}, data} << shamt;
  assign acc_base = idle ? '0 : st_i.accumulator;

  always_comb begin
    st_o  = '0;
    res_o = '0;
    emit_o = 1'b0;
    if (byte_i == '0) begin
      // End of string: report whether a sequence was left open, then clear.
      res_o.is_end   = 1'b1;
      res_o.complete = idle;
      emit_o         = 1'b1;
    end else if (byte_i < ubsd_pkg::AsciiLimit) begin
      st_o.accumulator = {{(ubsd_pkg::CpW-ubsd_pkg::ByteW){1'b0}}, byte_i};
      res_o.cp_value   = st_o.accumulator;
      emit_o           = 1'b1;
    end else begin
      st_o.bytes_left  = left_new;
      st_o.accumulator = acc_base | shifted;
      res_o.cp_value   = st_o.accumulator;
      emit_o           = (left_new == '0);
    end
  end

endmodule
